// File: src/rgb_light_effect_sequencer_core_defines.svh
// ----------------------------------------------------------------------------
// RGB light effect sequencer - assertion macros
// Concurrent assertion wrappers shared by the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef RGB_LIGHT_EFFECT_SEQUENCER_CORE_DEFINES_SVH
`define RGB_LIGHT_EFFECT_SEQUENCER_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define RLES_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define RLES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define RLES_ASSERT(label, clk, rst_n, prop, msg)
`define RLES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/rles_pkg.sv
// ----------------------------------------------------------------------------
// rles_pkg
// Types, codes and pattern tables of the RGB light effect sequencer.
// ----------------------------------------------------------------------------
package rles_pkg;

  // mode codes
  localparam logic [2:0] MODE_OFF   = 3'd0;
  localparam logic [2:0] MODE_POTS  = 3'd1;
  localparam logic [2:0] MODE_SLOW  = 3'd2;
  localparam logic [2:0] MODE_FAST  = 3'd3;
  localparam logic [2:0] MODE_SWEEP = 3'd4;

  // wait codes
  localparam logic [1:0] WAIT_10US  = 2'd0;
  localparam logic [1:0] WAIT_10MS  = 2'd1;
  localparam logic [1:0] WAIT_50MS  = 2'd2;
  localparam logic [1:0] WAIT_250MS = 2'd3;

  // last step of each pass
  localparam logic [4:0] LAST_SINGLE = 5'd0;
  localparam logic [4:0] LAST_POTS   = 5'd1;
  localparam logic [4:0] LAST_SLOW   = 5'd4;
  localparam logic [4:0] LAST_FAST   = 5'd16;

  // sweep direction flag bits
  localparam int unsigned FLAG_R_UP = 0;
  localparam int unsigned FLAG_G_UP = 1;
  localparam int unsigned FLAG_B_UP = 2;
  localparam int unsigned FLAG_R_DN = 3;
  localparam int unsigned FLAG_G_DN = 4;
  localparam int unsigned FLAG_B_DN = 5;

  // duty register slots
  localparam int unsigned DUTY_R = 0;
  localparam int unsigned DUTY_G = 1;
  localparam int unsigned DUTY_B = 2;
  localparam int unsigned DUTY_A = 3;
  localparam int unsigned DUTY_L = 4;

  typedef logic [2:0][7:0] rgb_lvl_t;
  typedef logic [4:0][7:0] duty_t;

  // architectural state of the sequencer
  typedef struct packed {
    logic [2:0] mode;
    logic [4:0] sub;
    logic       pend;
    rgb_lvl_t   lvl;
    logic [5:0] flags;
    duty_t      duty;
  } rles_state_t;

  localparam rles_state_t STATE_RST = '{
    mode:  MODE_SWEEP,
    sub:   5'd0,
    pend:  1'b0,
    lvl:   '0,
    flags: 6'b100001,
    duty:  '0
  };

  // slow blink pattern
  function automatic logic [7:0] slow_val(input logic [2:0] idx);
    logic [7:0] v;
    case (idx)
      3'd1:    v = 8'h6F;
      3'd2:    v = 8'hFF;
      3'd3:    v = 8'hFF;
      3'd4:    v = 8'h6F;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

  // fast ramp pattern
  function automatic logic [7:0] fast_val(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd1:    v = 8'h20;
      5'd2:    v = 8'hFF;
      5'd3:    v = 8'h40;
      5'd4:    v = 8'hDF;
      5'd5:    v = 8'h60;
      5'd6:    v = 8'hBF;
      5'd7:    v = 8'h80;
      5'd8:    v = 8'h6F;
      5'd9:    v = 8'hA0;
      5'd10:   v = 8'h6F;
      5'd11:   v = 8'hC0;
      5'd12:   v = 8'h5F;
      5'd13:   v = 8'hE0;
      5'd14:   v = 8'h3F;
      5'd15:   v = 8'hFF;
      5'd16:   v = 8'h1F;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

// File: src/rles_sweep.sv
// ----------------------------------------------------------------------------
// rles_sweep
// One step of the RGB color sweep: six ordered flag checks with 8-bit wrap.
// ----------------------------------------------------------------------------
module rles_sweep import rles_pkg::*; (
  input  rgb_lvl_t   lvl_i,
  input  logic [5:0] flags_i,
  output rgb_lvl_t   lvl_o,
  output logic [5:0] flags_o
);

  rgb_lvl_t   lvl;
  logic [5:0] f;

  // flags are tested in order; an earlier update can enable a later check
  always_comb begin
    lvl = lvl_i;
    f   = flags_i;
    if (f[FLAG_R_UP]) begin
      lvl[DUTY_R] = lvl[DUTY_R] + 8'd1;
      if (lvl[DUTY_R] == 8'hFF) begin
        f[FLAG_G_UP] = 1'b1;
        f[FLAG_B_DN] = 1'b1;
        f[FLAG_R_UP] = 1'b0;
      end
    end
    if (f[FLAG_G_UP]) begin
      lvl[DUTY_G] = lvl[DUTY_G] + 8'd1;
      if (lvl[DUTY_G] == 8'hFF) begin
        f[FLAG_B_UP] = 1'b1;
        f[FLAG_R_DN] = 1'b1;
        f[FLAG_G_UP] = 1'b0;
      end
    end
    if (f[FLAG_B_UP]) begin
      lvl[DUTY_B] = lvl[DUTY_B] + 8'd1;
      if (lvl[DUTY_B] == 8'hFF) begin
        f[FLAG_R_UP] = 1'b1;
        f[FLAG_G_DN] = 1'b1;
        f[FLAG_B_UP] = 1'b0;
      end
    end
    if (f[FLAG_R_DN]) begin
      lvl[DUTY_R] = lvl[DUTY_R] - 8'd1;
      if (lvl[DUTY_R] == 8'h00) begin
        f[FLAG_G_DN] = 1'b1;
        f[FLAG_R_DN] = 1'b0;
      end
    end
    if (f[FLAG_G_DN]) begin
      lvl[DUTY_G] = lvl[DUTY_G] - 8'd1;
      if (lvl[DUTY_G] == 8'h00) begin
        f[FLAG_B_DN] = 1'b1;
        f[FLAG_G_DN] = 1'b0;
      end
    end
    if (f[FLAG_B_DN]) begin
      lvl[DUTY_B] = lvl[DUTY_B] - 8'd1;
      if (lvl[DUTY_B] == 8'h00) begin
        f[FLAG_R_DN] = 1'b1;
        f[FLAG_B_DN] = 1'b0;
      end
    end
  end

  assign lvl_o   = lvl;
  assign flags_o = f;

endmodule

// File: src/rles_step.sv
// ----------------------------------------------------------------------------
// rles_step
// Next-state logic of one timing step: mode pass, sub-step and mode advance.
// ----------------------------------------------------------------------------
module rles_step import rles_pkg::*; (
  input  rles_state_t state_i,
  input  logic        button_press_i,
  input  logic [7:0]  pot_red_i,
  input  logic [7:0]  pot_green_i,
  input  logic [7:0]  pot_blue_i,
  output rles_state_t state_o,
  output logic [1:0]  wait_code_o
);

  rles_state_t nxt;
  rgb_lvl_t    sw_lvl;
  logic [5:0]  sw_flags;
  logic        pend;
  logic [4:0]  s;
  logic [4:0]  last;
  logic [1:0]  wait_code;

  rles_sweep u_sweep (
    .lvl_i   (state_i.lvl),
    .flags_i (state_i.flags),
    .lvl_o   (sw_lvl),
    .flags_o (sw_flags)
  );

  always_comb begin
    nxt       = state_i;
    pend      = state_i.pend | button_press_i;
    s         = state_i.sub;
    last      = LAST_SINGLE;
    wait_code = WAIT_250MS;

    // per-mode duty updates
    unique case (state_i.mode)
      MODE_POTS: begin
        last = LAST_POTS;
        if (s == 5'd0) begin
          nxt.duty[DUTY_R] = pot_red_i;
          nxt.duty[DUTY_G] = pot_green_i;
          nxt.duty[DUTY_B] = pot_blue_i;
          wait_code        = WAIT_10MS;
        end
      end
      MODE_SLOW: begin
        last = LAST_SLOW;
        if (s > last) s = last;
        if (s == 5'd0) begin
          nxt.duty[DUTY_A] = 8'h00;
          nxt.duty[DUTY_L] = 8'h00;
        end else if (s[0]) begin
          nxt.duty[DUTY_A] = slow_val(s[2:0]);
        end else begin
          nxt.duty[DUTY_L] = slow_val(s[2:0]);
        end
      end
      MODE_FAST: begin
        last      = LAST_FAST;
        wait_code = WAIT_50MS;
        if (s > last) s = last;
        if (s == 5'd0) begin
          nxt.duty[DUTY_A] = 8'h00;
          nxt.duty[DUTY_L] = 8'h00;
        end else if (s[0]) begin
          nxt.duty[DUTY_A] = fast_val(s);
        end else begin
          nxt.duty[DUTY_L] = fast_val(s);
        end
      end
      MODE_SWEEP: begin
        wait_code        = WAIT_10US;
        nxt.lvl          = sw_lvl;
        nxt.flags        = sw_flags;
        nxt.duty[DUTY_R] = sw_lvl[DUTY_R];
        nxt.duty[DUTY_G] = sw_lvl[DUTY_G];
        nxt.duty[DUTY_B] = sw_lvl[DUTY_B];
      end
      default: begin
        // off and unused codes hold everything
      end
    endcase

    // end of pass: take a pending press
    nxt.pend = pend;
    if (s >= last) begin
      nxt.sub = 5'd0;
      if (pend) begin
        nxt.mode = (state_i.mode >= MODE_SWEEP) ? MODE_OFF : state_i.mode + 3'd1;
        nxt.pend = 1'b0;
      end
    end else begin
      nxt.sub = s + 5'd1;
    end
  end

  assign state_o     = nxt;
  assign wait_code_o = wait_code;

endmodule

// File: src/rgb_light_effect_sequencer_core.sv
// ----------------------------------------------------------------------------
// rgb_light_effect_sequencer_core
// Five-mode RGB and lamp effect sequencer, one timing step per input beat.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+----------------------------
//  in      | sink      | in_valid_i / in_stall_o   | button press, three pots
//  out     | source    | out_valid_o / out_stall_i | 5 duties, mode, wait code
//
//  One beat per cycle sustained while out_stall_i is low; a result is valid
//  once its input beat has passed the input register and then the step logic
//  into the state and wait registers.
//  Reset: mode 4 (sweep), sweep red up and blue down, all duties zero.
//  A stalled result holds; the input register still takes a beat while the
//  result waits, and in_stall_o rises only once both stages are full.
// ----------------------------------------------------------------------------
`include "rgb_light_effect_sequencer_core_defines.svh"

module rgb_light_effect_sequencer_core import rles_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       button_press_i,
  input  logic [7:0] pot_red_i,
  input  logic [7:0] pot_green_i,
  input  logic [7:0] pot_blue_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_duty_o,
  output logic [7:0] green_duty_o,
  output logic [7:0] blue_duty_o,
  output logic [7:0] lamp_a_duty_o,
  output logic [7:0] lamp_b_duty_o,
  output logic [2:0] mode_now_o,
  output logic [1:0] wait_code_o
);

  logic        in_vld_q, in_vld_d;
  logic        out_vld_q, out_vld_d;
  logic        btn_q;
  logic [7:0]  pot_r_q, pot_g_q, pot_b_q;
  rles_state_t state_q, state_d;
  logic [1:0]  wait_q, wait_d;
  logic        in_load;
  logic        step_go;

  // handshake: a step runs when the result slot is free or being drained
  assign step_go    = in_vld_q & (~out_vld_q | ~out_stall_i);
  assign in_stall_o = in_vld_q & ~step_go;
  assign in_load    = in_valid_i & ~in_stall_o;

  assign in_vld_d  = in_load | (in_vld_q & ~step_go);
  assign out_vld_d = step_go | (out_vld_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // input beat register
  always_ff @(posedge clk_i) begin
    if (in_load) begin
      btn_q   <= button_press_i;
      pot_r_q <= pot_red_i;
      pot_g_q <= pot_green_i;
      pot_b_q <= pot_blue_i;
    end
  end

  // step logic
  rles_step u_step (
    .state_i        (state_q),
    .button_press_i (btn_q),
    .pot_red_i      (pot_r_q),
    .pot_green_i    (pot_g_q),
    .pot_blue_i     (pot_b_q),
    .state_o        (state_d),
    .wait_code_o    (wait_d)
  );

  // sequencer state; duties and mode double as the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RST;
    end else if (step_go) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go) begin
      wait_q <= wait_d;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign red_duty_o    = state_q.duty[DUTY_R];
  assign green_duty_o  = state_q.duty[DUTY_G];
  assign blue_duty_o   = state_q.duty[DUTY_B];
  assign lamp_a_duty_o = state_q.duty[DUTY_A];
  assign lamp_b_duty_o = state_q.duty[DUTY_L];
  assign mode_now_o    = state_q.mode;
  assign wait_code_o   = wait_q;

  // checks
  `RLES_ASSERT(a_mode_range, clk_i, rst_ni, state_q.mode <= MODE_SWEEP, "mode out of range")
  `RLES_ASSERT(a_sub_in_pass, clk_i, rst_ni,
    (state_q.sub == 5'd0) || (state_q.mode == MODE_POTS) ||
    (state_q.mode == MODE_SLOW) || (state_q.mode == MODE_FAST),
    "sub-step set in single-step mode")
  `RLES_ASSERT(a_flags_live, clk_i, rst_ni, state_q.flags != 6'd0, "sweep flags all clear")
  `RLES_ASSERT_NEXT(a_state_hold, clk_i, rst_ni, !step_go, $stable(state_q),
    "state changed without a step")

endmodule

// File: tb/rgb_light_effect_sequencer_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_light_effect_sequencer_core_tb
// Self-checking bench for the lamp effect sequencer. A scoreboard predicts
// every step result from its own copy of the sequencer state. A short
// directed walk goes through every mode and pass. Long random runs follow,
// with few button presses in sweep mode so the color sweep goes deep. Both
// channels idle and stall at random, with quiet stretches between.
// ----------------------------------------------------------------------------
import rles_pkg::*;

// one result beat: five duties, mode and wait code
typedef struct {
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] lamp_a;
  logic [7:0] lamp_b;
  logic [2:0] mode;
  logic [1:0] wait_code;
} lamp_frame_t;

class lamp_step_scoreboard;
  logic [2:0]  mode;
  logic [4:0]  sub;
  bit          pend;
  logic [7:0]  lvl [3];
  logic [5:0]  flags;
  logic [7:0]  duty [5];
  logic [7:0]  blink_pat [5];
  logic [7:0]  ramp_pat [17];
  lamp_frame_t expected_frames [$];
  int unsigned fails;

  function new();
    blink_pat = '{8'h00, 8'h6F, 8'hFF, 8'hFF, 8'h6F};
    ramp_pat  = '{8'h00, 8'h20, 8'hFF, 8'h40, 8'hDF, 8'h60, 8'hBF, 8'h80, 8'h6F,
                  8'hA0, 8'h6F, 8'hC0, 8'h5F, 8'hE0, 8'h3F, 8'hFF, 8'h1F};
    mode  = MODE_SWEEP;
    sub   = '0;
    pend  = 1'b0;
    lvl   = '{default: 8'h00};
    duty  = '{default: 8'h00};
    flags = '0;
    flags[FLAG_R_UP] = 1'b1;
    flags[FLAG_B_DN] = 1'b1;
    fails = 0;
  endfunction

  // one sweep step: flags tested in order, each one sees earlier changes
  function void sweep_once();
    logic [5:0] f;
    f = flags;
    if (f[FLAG_R_UP]) begin
      lvl[0] = lvl[0] + 8'd1;
      if (lvl[0] == 8'hFF) begin
        f[FLAG_R_UP] = 1'b0; f[FLAG_G_UP] = 1'b1; f[FLAG_B_DN] = 1'b1;
      end
    end
    if (f[FLAG_G_UP]) begin
      lvl[1] = lvl[1] + 8'd1;
      if (lvl[1] == 8'hFF) begin
        f[FLAG_G_UP] = 1'b0; f[FLAG_B_UP] = 1'b1; f[FLAG_R_DN] = 1'b1;
      end
    end
    if (f[FLAG_B_UP]) begin
      lvl[2] = lvl[2] + 8'd1;
      if (lvl[2] == 8'hFF) begin
        f[FLAG_B_UP] = 1'b0; f[FLAG_R_UP] = 1'b1; f[FLAG_G_DN] = 1'b1;
      end
    end
    if (f[FLAG_R_DN]) begin
      lvl[0] = lvl[0] - 8'd1;
      if (lvl[0] == 8'h00) begin
        f[FLAG_R_DN] = 1'b0; f[FLAG_G_DN] = 1'b1;
      end
    end
    if (f[FLAG_G_DN]) begin
      lvl[1] = lvl[1] - 8'd1;
      if (lvl[1] == 8'h00) begin
        f[FLAG_G_DN] = 1'b0; f[FLAG_B_DN] = 1'b1;
      end
    end
    if (f[FLAG_B_DN]) begin
      lvl[2] = lvl[2] - 8'd1;
      if (lvl[2] == 8'h00) begin
        f[FLAG_B_DN] = 1'b0; f[FLAG_R_DN] = 1'b1;
      end
    end
    flags = f;
    duty[DUTY_R] = lvl[0];
    duty[DUTY_G] = lvl[1];
    duty[DUTY_B] = lvl[2];
  endfunction

  // accepted input beat: advance the predicted state, queue the result
  function void note_step(bit press, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    logic [4:0]  s;
    logic [4:0]  last;
    logic [1:0]  wcode;
    lamp_frame_t fr;
    s = sub;
    if (press) pend = 1'b1;
    case (mode)
      MODE_POTS: begin
        last = LAST_POTS;
        if (s == 5'd0) begin
          duty[DUTY_R] = r;
          duty[DUTY_G] = g;
          duty[DUTY_B] = b;
          wcode = WAIT_10MS;
        end else begin
          wcode = WAIT_250MS;
        end
      end
      MODE_SLOW: begin
        last = LAST_SLOW;
        if (s > last) s = last;
        if (s == 5'd0) begin
          duty[DUTY_A] = 8'h00;
          duty[DUTY_L] = 8'h00;
        end else if (s[0]) begin
          duty[DUTY_A] = blink_pat[s];
        end else begin
          duty[DUTY_L] = blink_pat[s];
        end
        wcode = WAIT_250MS;
      end
      MODE_FAST: begin
        last = LAST_FAST;
        if (s > last) s = last;
        if (s == 5'd0) begin
          duty[DUTY_A] = 8'h00;
          duty[DUTY_L] = 8'h00;
        end else if (s[0]) begin
          duty[DUTY_A] = ramp_pat[s];
        end else begin
          duty[DUTY_L] = ramp_pat[s];
        end
        wcode = WAIT_50MS;
      end
      MODE_SWEEP: begin
        last = LAST_SINGLE;
        sweep_once();
        wcode = WAIT_10US;
      end
      default: begin
        // off, and any unused code, holds everything
        last = LAST_SINGLE;
        wcode = WAIT_250MS;
      end
    endcase
    // end of pass: a pending press moves the mode on
    if (s >= last) begin
      sub = 5'd0;
      if (pend) begin
        mode = (mode >= MODE_SWEEP) ? MODE_OFF : mode + 3'd1;
        pend = 1'b0;
      end
    end else begin
      sub = s + 5'd1;
    end
    fr.red       = duty[DUTY_R];
    fr.green     = duty[DUTY_G];
    fr.blue      = duty[DUTY_B];
    fr.lamp_a    = duty[DUTY_A];
    fr.lamp_b    = duty[DUTY_L];
    fr.mode      = mode;
    fr.wait_code = wcode;
    expected_frames.push_back(fr);
  endfunction

  function void compare_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
      fails++;
    end
  endfunction

  // accepted result beat against the oldest prediction
  function void check_frame(lamp_frame_t got);
    lamp_frame_t exp_fr;
    if (expected_frames.size() == 0) begin
      $error("result beat with no step outstanding");
      fails++;
      return;
    end
    exp_fr = expected_frames.pop_front();
    compare_field("red_duty",    exp_fr.red,       got.red);
    compare_field("green_duty",  exp_fr.green,     got.green);
    compare_field("blue_duty",   exp_fr.blue,      got.blue);
    compare_field("lamp_a_duty", exp_fr.lamp_a,    got.lamp_a);
    compare_field("lamp_b_duty", exp_fr.lamp_b,    got.lamp_b);
    compare_field("mode_now",    exp_fr.mode,      got.mode);
    compare_field("wait_code",   exp_fr.wait_code, got.wait_code);
  endfunction

  function void check_drained();
    if (expected_frames.size() != 0) begin
      $error("%0d step results never arrived", expected_frames.size());
      fails++;
    end
  endfunction
endclass

module rgb_light_effect_sequencer_core_tb;

  localparam int unsigned RANDOM_STEPS = 1850;

  logic       clk_i          = 1'b0;
  logic       rst_ni         = 1'b0;
  logic       in_valid_i     = 1'b0;
  logic       button_press_i = 1'b0;
  logic [7:0] pot_red_i      = 8'h00;
  logic [7:0] pot_green_i    = 8'h00;
  logic [7:0] pot_blue_i     = 8'h00;
  logic       out_stall_i    = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [7:0] red_duty_o;
  logic [7:0] green_duty_o;
  logic [7:0] blue_duty_o;
  logic [7:0] lamp_a_duty_o;
  logic [7:0] lamp_b_duty_o;
  logic [2:0] mode_now_o;
  logic [1:0] wait_code_o;

  // no idling on either side while set
  bit          quiet_phase = 1'b0;
  int unsigned stall_left  = 0;

  lamp_step_scoreboard sb = new();

  rgb_light_effect_sequencer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .button_press_i (button_press_i),
    .pot_red_i      (pot_red_i),
    .pot_green_i    (pot_green_i),
    .pot_blue_i     (pot_blue_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_duty_o     (red_duty_o),
    .green_duty_o   (green_duty_o),
    .blue_duty_o    (blue_duty_o),
    .lamp_a_duty_o  (lamp_a_duty_o),
    .lamp_b_duty_o  (lamp_b_duty_o),
    .mode_now_o     (mode_now_o),
    .wait_code_o    (wait_code_o)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // watch both channels; results first, they always trail their steps
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_frame('{red: red_duty_o, green: green_duty_o, blue: blue_duty_o,
                         lamp_a: lamp_a_duty_o, lamp_b: lamp_b_duty_o,
                         mode: mode_now_o, wait_code: wait_code_o});
      end
      if (in_valid_i && !in_stall_o) begin
        sb.note_step(button_press_i, pot_red_i, pot_green_i, pot_blue_i);
      end
    end
  end

  // result side: after each accepted beat, draw at random whether and how long to stall
  always @(posedge clk_i) begin : stall_gen
    int unsigned pick;
    if (out_stall_i) begin
      if (stall_left <= 1) out_stall_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rst_ni && out_valid_o) begin
      pick = quiet_phase ? 0 : $urandom_range(0, 5);
      if (pick != 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= pick;
      end
    end
  end

  // pot reading with the extremes weighted up
  function automatic logic [7:0] pick_pot();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // present one step beat after a random gap, return once it is taken
  task automatic send_step(input bit press, input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    int unsigned gap;
    gap = quiet_phase ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    button_press_i <= press;
    pot_red_i      <= r;
    pot_green_i    <= g;
    pot_blue_i     <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  initial begin
    int unsigned guard;
    bit          press;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed walk: sweep -> off -> pots -> slow -> fast -> sweep
    send_step(1'b0, 8'h00, 8'h00, 8'h00);
    send_step(1'b1, 8'hFF, 8'hFF, 8'hFF);
    send_step(1'b1, 8'hAA, 8'h55, 8'hAA);
    // press on the first pots step stays pending to the pass end
    send_step(1'b1, 8'h00, 8'hFF, 8'h00);
    send_step(1'b0, 8'hFF, 8'h00, 8'hFF);
    for (int i = 0; i < 5; i++) begin
      send_step(i == 2, 8'hFF, 8'h00, 8'h55);
    end
    // fast ramp, press only on its last step
    for (int i = 0; i < 17; i++) begin
      send_step(i == 16, 8'h00, 8'hFF, 8'hAA);
    end

    // random steps; sweep mode rarely sees a press so its levels go deep
    for (int n = 0; n < RANDOM_STEPS; n++) begin
      if (n % 150 == 0) quiet_phase <= ($urandom_range(0, 2) == 0);
      if (sb.mode == MODE_SWEEP) press = ($urandom_range(0, 399) == 0);
      else                       press = ($urandom_range(0, 5) == 0);
      send_step(press, pick_pot(), pick_pot(), pick_pot());
    end
    in_valid_i <= 1'b0;

    // drain, then keep watching for anything unexpected
    guard = 0;
    while (sb.expected_frames.size() != 0 && guard < 1000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (10) @(posedge clk_i);
    sb.check_drained();

    if (sb.fails == 0) begin
      $display("rgb_light_effect_sequencer_core verification clean");
    end else begin
      $display("rgb_light_effect_sequencer_core verification failed");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("rgb_light_effect_sequencer_core verification failed");
    $finish;
  end

endmodule
